/* src/clf_pkg.sv */
// Shared types and character codes for the console line formatter.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package clf_pkg;

  // Character codes the formatter reacts to
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Datapath operations requested by the controller
  typedef struct packed {
    logic load_char;    // capture the accepted character
    logic store_char;   // write one byte at the cursor and advance it
    logic emit_read;    // read the word of the current group
    logic emit_next;    // advance to the next group
    logic emit_finish;  // line done: cursor home, next row
  } clf_cmd_t;

  // Conditions reported back by the datapath
  typedef struct packed {
    logic in_ignored;   // incoming byte is NUL or CR
    logic in_newline;   // incoming byte is LF
    logic tab_active;   // held character is a tab
    logic store_wraps;  // next store reaches the last usable column
    logic tab_stop;     // next store lands on a tab stop
    logic last_group;   // current group is the final one of the line
  } clf_status_t;

endpackage : clf_pkg

`default_nettype wire

/* src/clf_ctrl.sv */
// Controller state machine of the console line formatter.
// Depends on clf_pkg; drives the datapath through clf_cmd_t and the stream handshakes.
`default_nettype none

module clf_ctrl
  import clf_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  input  clf_status_t status_i,
  output clf_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_STORE    = 4'b0010,
    ST_EMIT_RD  = 4'b0100,
    ST_EMIT_OUT = 4'b1000
  } clf_state_e;

  clf_state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_char = 1'b1;
          priority if (status_i.in_ignored) begin
            state_d = ST_IDLE;
          end else if (status_i.in_newline) begin
            state_d = ST_EMIT_RD;
          end else begin
            state_d = ST_STORE;
          end
        end
      end
      ST_STORE: begin
        cmd_o.store_char = 1'b1;
        priority if (status_i.store_wraps) begin
          state_d = ST_EMIT_RD;
        end else if (status_i.tab_active && !status_i.tab_stop) begin
          state_d = ST_STORE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        cmd_o.emit_read = 1'b1;
        state_d         = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_ready_i) begin
          if (status_i.last_group) begin
            cmd_o.emit_finish = 1'b1;
            state_d           = ST_IDLE;
          end else begin
            cmd_o.emit_next = 1'b1;
            state_d         = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT_OUT);

endmodule : clf_ctrl

`default_nettype wire

/* src/clf_dp.sv */
// Datapath of the console line formatter: line buffer, cursor, row and group counters.
// Depends on clf_pkg; commanded by clf_ctrl through clf_cmd_t.
`default_nettype none

module clf_dp
  import clf_pkg::*;
#(
  parameter int LINE_COLUMNS = 80,
  parameter int SCREEN_ROWS  = 24,
  parameter int TAB_WIDTH    = 8
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire  [7:0]   in_char_i,
  input  clf_cmd_t     cmd_i,
  output clf_status_t  status_o,
  output logic [63:0]  out_chars_o,   // char_0 .. char_7, from the lowest bit up
  output logic [8:0]   out_tags_o,    // row_index [4:0], word_index [8:5]
  output logic         out_last_o
);

  localparam int GROUPS = (LINE_COLUMNS + 7) / 8;
  localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int EW     = GW + 3;
  localparam int CLW    = $clog2(LINE_COLUMNS);
  localparam int RW     = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
  localparam int TW     = $clog2(TAB_WIDTH);

  logic [7:0]     char_q;
  logic [CLW-1:0] col_q;
  logic [TW-1:0]  tab_q;
  logic [RW-1:0]  row_q;
  logic [GW-1:0]  grp_q;
  logic [63:0]    rdata_q;
  logic [63:0]    mem_q [GROUPS];

  logic [7:0]     wr_byte;
  logic [GW-1:0]  wr_addr;
  logic [2:0]     wr_lane;
  logic [31:0]    row_ext;
  logic [31:0]    grp_ext;

  // Classify the incoming byte and the held one
  assign status_o.in_ignored  = (in_char_i == CH_NUL) || (in_char_i == CH_CR);
  assign status_o.in_newline  = (in_char_i == CH_LF);
  assign status_o.tab_active  = (char_q == CH_TAB);
  assign status_o.store_wraps = (col_q == CLW'(LINE_COLUMNS - 2));
  assign status_o.tab_stop    = (tab_q == TW'(TAB_WIDTH - 1));
  assign status_o.last_group  = (grp_q == GW'(GROUPS - 1));

  // Hold the accepted character
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_char) begin
      char_q <= in_char_i;
    end
  end

  // Cursor, tab phase, row and group counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      tab_q <= '0;
      row_q <= '0;
      grp_q <= '0;
    end else begin
      if (cmd_i.store_char) begin
        col_q <= col_q + 1'b1;
        tab_q <= status_o.tab_stop ? '0 : tab_q + 1'b1;
      end
      if (cmd_i.emit_next) begin
        grp_q <= grp_q + 1'b1;
      end
      if (cmd_i.emit_finish) begin
        col_q <= '0;
        tab_q <= '0;
        grp_q <= '0;
        row_q <= (row_q == RW'(SCREEN_ROWS - 1)) ? '0 : row_q + 1'b1;
      end
    end
  end

  // Line buffer: one word per group, byte-wide writes
  assign wr_byte = (char_q == CH_TAB) ? CH_SPACE : char_q;
  assign wr_addr = GW'(col_q >> 3);
  assign wr_lane = col_q[2:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_char) begin
      mem_q[wr_addr][wr_lane*8 +: 8] <= wr_byte;
    end
    if (cmd_i.emit_read) begin
      rdata_q <= mem_q[grp_q];
    end
  end

  // Fill columns past the cursor with spaces and the final column with a terminator
  always_comb begin
    logic [EW-1:0] pos;
    for (int k = 0; k < 8; k++) begin
      pos = {grp_q, 3'(k)};
      if (pos < EW'(col_q)) begin
        out_chars_o[k*8 +: 8] = rdata_q[k*8 +: 8];
      end else if (pos < EW'(LINE_COLUMNS - 1)) begin
        out_chars_o[k*8 +: 8] = CH_SPACE;
      end else begin
        out_chars_o[k*8 +: 8] = CH_NUL;
      end
    end
  end

  // Tags, masked to their field widths
  assign row_ext    = 32'(row_q);
  assign grp_ext    = 32'(grp_q);
  assign out_tags_o = {grp_ext[3:0], row_ext[4:0]};
  assign out_last_o = status_o.last_group;

endmodule : clf_dp

`default_nettype wire

/* src/console_line_formatter.sv */
// A NUL or CR is dropped; a printable character is written at the cursor;
// a tab writes spaces up to the next tab stop (1..TAB_WIDTH spaces).
// A newline or wrap emits ceil(LINE_COLUMNS/8) words, each by a line buffer read,
// then the held word on offer until the output takes it.
// One item is worked on at a time. Reset is asynchronous, active low: cursor, row and
// tab phase clear; the line buffer is not cleared.
`default_nettype none

module console_line_formatter
  import clf_pkg::*;
#(
  parameter int LINE_COLUMNS = 80,
  parameter int SCREEN_ROWS  = 24,
  parameter int TAB_WIDTH    = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // char_code [7:0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [63:0] m_axis_tdata,   // char_0 [7:0], char_1 [15:8], ... char_7 [63:56]
  output logic [8:0]  m_axis_tuser,   // row_index [4:0], word_index [8:5]
  output logic        m_axis_tlast    // last_word
);

  clf_cmd_t    cmd;
  clf_status_t status;

  clf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  clf_dp #(
    .LINE_COLUMNS (LINE_COLUMNS),
    .SCREEN_ROWS  (SCREEN_ROWS),
    .TAB_WIDTH    (TAB_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_char_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_chars_o (m_axis_tdata),
    .out_tags_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  // Input is never taken while a word is on offer
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while output valid");

  // The final word of a line returns the block to accepting input
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("not ready after last word of a line");

  // After a non-final word the next one is fetched first
  a_next_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (!m_axis_tvalid && !s_axis_tready))
    else $error("line emission interrupted");
`endif

endmodule : console_line_formatter

`default_nettype wire
